/* hw/rtl/iit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iit_pkg: shared types and constants of the interrupt / I/O / timer interface
// Word layouts, action codes and bus address constants used by the processing
// core, the top level and the testbench.
// ----------------------------------------------------------------------------
package iit_pkg;

	localparam int LineCount  = 16;
	localparam int IntervalW  = 14;
	localparam int LineW      = 4;
	localparam int OffsetW    = 5;
	localparam int ByteW      = 8;

	// Bus address map of the single-bit write space.
	localparam logic [OffsetW-1:0] OfsMode      = 5'd0;
	localparam logic [OffsetW-1:0] OfsLastMask  = 5'd14;
	localparam logic [OffsetW-1:0] OfsSoftReset = 5'd15;
	localparam logic [OffsetW-1:0] OfsFirstPin  = 5'd16;

	// Interrupt line that the timer takes over while an interval is loaded.
	localparam logic [LineW-1:0] TimerLine = 4'd3;

	// Pins at or above this number are mirrored onto lines MirrorBase - pin.
	localparam logic [LineW-1:0]   MirrorFirstPin = 4'd7;
	localparam logic [OffsetW-1:0] MirrorBase     = 5'd22;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_LINE  = 2'd2,
		ACT_TICK  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CHUNK_LOW_LINES  = 2'd0,
		CHUNK_HIGH_LINES = 2'd1,
		CHUNK_LOW_PINS   = 2'd2,
		CHUNK_HIGH_PINS  = 2'd3
	} chunk_t;

	// One input word as held in the input register.
	typedef struct packed {
		action_t            action;
		logic [OffsetW-1:0] bus_offset;
		logic               bit_value;
		logic [LineW-1:0]   line_index;
		logic [ByteW-1:0]   external_byte;
	} item_t;

	// One result word as held in the output register.
	typedef struct packed {
		logic [ByteW-1:0] read_data;
		logic             intreq;
		logic [LineW-1:0] int_level;
		logic             pin_write;
		logic [LineW-1:0] pin_id;
		logic             pin_value;
	} result_t;

endpackage

/* hw/rtl/iit_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iit_ifs: channel interfaces of the interrupt / I/O / timer interface
// Valid/ready channels for input words, result words and configuration writes.
// ----------------------------------------------------------------------------

// Input word channel.
interface iit_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [4:0] bus_offset;
	logic       bit_value;
	logic [3:0] line_index;
	logic [7:0] external_byte;

	modport source (
		output valid, action, bus_offset, bit_value, line_index, external_byte,
		input  ready
	);
	modport sink (
		input  valid, action, bus_offset, bit_value, line_index, external_byte,
		output ready
	);
endinterface

// Result word channel.
interface iit_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       intreq;
	logic [3:0] int_level;
	logic       pin_write;
	logic [3:0] pin_id;
	logic       pin_value;

	modport source (
		output valid, read_data, intreq, int_level, pin_write, pin_id, pin_value,
		input  ready
	);
	modport sink (
		input  valid, read_data, intreq, int_level, pin_write, pin_id, pin_value,
		output ready
	);
endinterface

// Configuration write channel for the interrupt pin mask.
interface iit_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] interrupt_pin_mask;

	modport source (
		output valid, interrupt_pin_mask,
		input  ready
	);
	modport sink (
		input  valid, interrupt_pin_mask,
		output ready
	);
endinterface

/* hw/rtl/interrupt_io_timer_interface.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_io_timer_interface: interrupt, I/O and timer interface
// Serial-bus system interface with interrupt mask, decrementer and I/O pins.
// ----------------------------------------------------------------------------
// The block returns exactly one result word for each word it accepts: the word
// is captured in an input register, processed against the held state
// combinationally, and the result is placed in an output register. Throughput
// is one word per cycle as long as the result side takes words; a stalled
// result holds the pipeline.
// The interrupt pin mask is written through the configuration channel, which
// is always ready, and must only be written while no word is in flight.
module interrupt_io_timer_interface (
	input  logic         clk,
	input  logic         arst_n,
	iit_item_if.sink     item,
	iit_result_if.source result,
	iit_cfg_if.sink      cfg
);
	import iit_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        res_valid_q;
	result_t     res_q;
	result_t     res_d;
	logic [15:0] pin_mask_q;
	logic        out_free;
	logic        step_en;

	// Handshake: the output register frees the stage, which frees the input.
	assign out_free   = !res_valid_q || result.ready;
	assign step_en    = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;
	assign cfg.ready  = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_mask_q <= '0;
		end else if (cfg.valid) begin
			pin_mask_q <= cfg.interrupt_pin_mask;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= '{action:        action_t'(item.action),
			             bus_offset:    item.bus_offset,
			             bit_value:     item.bit_value,
			             line_index:    item.line_index,
			             external_byte: item.external_byte};
		end
	end

	iit_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (step_en),
		.itm      (item_s1),
		.pin_mask (pin_mask_q),
		.res      (res_d)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res_d;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.read_data  = res_q.read_data;
	assign result.intreq     = res_q.intreq;
	assign result.int_level  = res_q.int_level;
	assign result.pin_write  = res_q.pin_write;
	assign result.pin_id     = res_q.pin_id;
	assign result.pin_value  = res_q.pin_value;

endmodule

/* hw/rtl/iit_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iit_core: state and single-pass processing of one word
// Holds the mode, timer, mask, line and pin state, and computes the next state
// and the result word of the word presented on step_en combinationally.
// ----------------------------------------------------------------------------
module iit_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  iit_pkg::item_t    itm,
	input  logic [15:0]       pin_mask,
	output iit_pkg::result_t  res
);
	import iit_pkg::*;

	// State registers.
	logic                 mode_q;
	logic [IntervalW-1:0] interval_q;
	logic                 chg_q;
	logic [IntervalW-1:0] dec_q;
	logic [IntervalW-1:0] latched_q;
	logic                 pending_q;
	logic [LineCount-1:0] en_q;
	logic [LineCount-1:0] levels_q;
	logic [LineCount-1:0] pdir_q;
	logic [LineCount-1:0] pout_q;
	logic [LineCount-1:0] mdir_q;
	logic [LineCount-1:0] mout_q;

	// Next-state values.
	logic                 mode_d;
	logic [IntervalW-1:0] interval_d;
	logic                 chg_d;
	logic [IntervalW-1:0] dec_d;
	logic [IntervalW-1:0] latched_d;
	logic                 pending_d;
	logic [LineCount-1:0] en_d;
	logic [LineCount-1:0] levels_d;
	logic [LineCount-1:0] pdir_d;
	logic [LineCount-1:0] pout_d;
	logic [LineCount-1:0] mdir_d;
	logic [LineCount-1:0] mout_d;

	logic                 do_leave;
	logic [LineCount-1:0] inv_lines;
	logic [LineCount-1:0] act_cur;
	logic [LineCount-1:0] act_nxt;
	logic [LineW-1:0]     pin;
	logic [LineW-1:0]     mirror_idx;
	logic [LineW-1:0]     ofs_lo;
	logic [IntervalW-1:0] dec_minus;

	// Lines that are active and enabled; the timer replaces its line while an
	// interval is loaded, and lines mirrored from output pins are masked off.
	function automatic logic [LineCount-1:0] active_ints(
		input logic [LineCount-1:0] levels,
		input logic [IntervalW-1:0] interval,
		input logic                 pending,
		input logic [LineCount-1:0] en,
		input logic [LineCount-1:0] mdir
	);
		logic [LineCount-1:0] cur;
		cur = levels;
		if (interval != '0) begin
			cur[TimerLine] = pending;
		end
		return cur & en & ~mdir;
	endfunction

	// Priority encoder: number of the lowest set bit, zero when none.
	function automatic logic [LineW-1:0] lowest_bit(input logic [LineCount-1:0] v);
		logic [LineW-1:0] n;
		n = '0;
		for (int i = LineCount - 1; i >= 0; i--) begin
			if (v[i]) begin
				n = LineW'(i);
			end
		end
		return n;
	endfunction

	assign inv_lines  = ~levels_q & pin_mask;
	assign act_cur    = active_ints(levels_q, interval_q, pending_q, en_q, mdir_q);
	assign pin        = itm.bus_offset[LineW-1:0];
	assign ofs_lo     = itm.bus_offset[LineW-1:0];
	assign mirror_idx = LineW'(MirrorBase - {1'b0, pin});
	assign dec_minus  = dec_q - IntervalW'(1);

	// Next state and result word for one word.
	always_comb begin
		mode_d     = mode_q;
		interval_d = interval_q;
		chg_d      = chg_q;
		dec_d      = dec_q;
		latched_d  = latched_q;
		pending_d  = pending_q;
		en_d       = en_q;
		levels_d   = levels_q;
		pdir_d     = pdir_q;
		pout_d     = pout_q;
		mdir_d     = mdir_q;
		mout_d     = mout_q;
		do_leave   = 1'b0;
		res        = '0;

		unique case (itm.action)
			ACT_READ: begin
				unique case (chunk_t'(itm.bus_offset[1:0]))
					CHUNK_LOW_LINES: begin
						if (mode_q) begin
							res.read_data = {latched_q[6:0], 1'b1};
						end else begin
							res.read_data = ((inv_lines[7:0] | itm.external_byte) & ~mdir_q[7:0])
								| (mout_q[7:0] & mdir_q[7:0]);
						end
					end
					CHUNK_HIGH_LINES: begin
						if (mode_q) begin
							res.read_data = {~(|act_cur), latched_q[13:7]};
						end else begin
							res.read_data = ((inv_lines[15:8] | itm.external_byte)
								& ~mdir_q[15:8]) | (mout_q[15:8] & mdir_q[15:8]);
						end
					end
					CHUNK_LOW_PINS: begin
						do_leave      = 1'b1;
						res.read_data = (itm.external_byte & ~pdir_q[7:0])
							| (pout_q[7:0] & pdir_q[7:0]);
					end
					CHUNK_HIGH_PINS: begin
						do_leave      = 1'b1;
						res.read_data = (itm.external_byte & ~pdir_q[15:8])
							| (pout_q[15:8] & pdir_q[15:8]);
					end
					default: ;
				endcase
			end
			ACT_WRITE: begin
				priority if (itm.bus_offset == OfsMode) begin
					// Mode bit: entering timer mode latches the decrementer.
					if (itm.bit_value && !mode_q) begin
						mode_d    = 1'b1;
						latched_d = (interval_q != '0) ? dec_q : '0;
						chg_d     = 1'b0;
					end else if (!itm.bit_value) begin
						do_leave = 1'b1;
					end
				end else if (itm.bus_offset <= OfsLastMask) begin
					if (mode_q) begin
						interval_d[ofs_lo - LineW'(1)] = itm.bit_value;
						chg_d                          = 1'b1;
					end else begin
						en_d[ofs_lo] = itm.bit_value;
						if (ofs_lo == TimerLine) begin
							pending_d = 1'b0;
						end
					end
				end else if (itm.bus_offset == OfsSoftReset) begin
					if (mode_q) begin
						if (!itm.bit_value) begin
							pdir_d = '0;
							mdir_d = '0;
							en_d   = '0;
						end
					end else begin
						en_d[LineCount-1] = itm.bit_value;
					end
				end else begin
					// Output pin write, with the mirror onto the upper lines.
					do_leave       = 1'b1;
					pdir_d[pin]    = 1'b1;
					pout_d[pin]    = itm.bit_value;
					if (pin >= MirrorFirstPin) begin
						mdir_d[mirror_idx] = 1'b1;
						mout_d[mirror_idx] = itm.bit_value;
					end
					res.pin_write  = 1'b1;
					res.pin_id     = pin;
					res.pin_value  = itm.bit_value;
				end
			end
			ACT_LINE: begin
				levels_d[itm.line_index] = itm.bit_value;
			end
			ACT_TICK: begin
				// A stopped decrementer ignores ticks; expiry sets the timer flag.
				if (dec_q != '0) begin
					if (dec_minus == '0) begin
						pending_d = 1'b1;
						dec_d     = interval_q;
					end else begin
						dec_d = dec_minus;
					end
				end
			end
			default: ;
		endcase

		// Leaving timer mode reloads the decrementer if the interval was changed.
		if (do_leave && mode_q) begin
			mode_d = 1'b0;
			if (chg_q) begin
				dec_d = interval_q;
			end
		end

		act_nxt       = active_ints(levels_d, interval_d, pending_d, en_d, mdir_d);
		res.intreq    = |act_nxt;
		res.int_level = lowest_bit(act_nxt);
	end

	// State update on each processed word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			interval_q <= '0;
			chg_q      <= 1'b0;
			dec_q      <= '0;
			latched_q  <= '0;
			pending_q  <= 1'b0;
			en_q       <= '0;
			levels_q   <= '0;
			pdir_q     <= '0;
			pout_q     <= '0;
			mdir_q     <= '0;
			mout_q     <= '0;
		end else if (step_en) begin
			mode_q     <= mode_d;
			interval_q <= interval_d;
			chg_q      <= chg_d;
			dec_q      <= dec_d;
			latched_q  <= latched_d;
			pending_q  <= pending_d;
			en_q       <= en_d;
			levels_q   <= levels_d;
			pdir_q     <= pdir_d;
			pout_q     <= pout_d;
			mdir_q     <= mdir_d;
			mout_q     <= mout_d;
		end
	end

endmodule

/* hw/rtl/iit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iit_checker: port-level checks of the interrupt / I/O / timer interface
// Watches the result channel for consistency of the reported words.
// ----------------------------------------------------------------------------
module iit_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] read_data,
	input logic       intreq,
	input logic [3:0] int_level,
	input logic       pin_write,
	input logic [3:0] pin_id,
	input logic       pin_value
);

	// A stalled result word keeps its valid and all its fields but the pin value.
	property p_hold;
		@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(read_data) && $stable(intreq)
			&& $stable(int_level) && $stable(pin_write) && $stable(pin_id);
	endproperty
	a_hold: assert property (p_hold) else $error("result word changed while stalled");

	// Without a pending interrupt the level reads as zero.
	property p_level_zero;
		@(posedge clk) disable iff (!arst_n)
		res_valid && !intreq |-> int_level == 4'd0;
	endproperty
	a_level_zero: assert property (p_level_zero) else $error("level set without intreq");

	// Pin number and value are zero unless a pin was driven.
	property p_pin_idle;
		@(posedge clk) disable iff (!arst_n)
		res_valid && !pin_write |-> pin_id == 4'd0 && pin_value == 1'b0;
	endproperty
	a_pin_idle: assert property (p_pin_idle) else $error("pin fields set without pin write");

	// A pin write comes from a bit write, which returns no read data.
	property p_pin_no_read;
		@(posedge clk) disable iff (!arst_n)
		res_valid && pin_write |-> read_data == 8'd0;
	endproperty
	a_pin_no_read: assert property (p_pin_no_read) else $error("read data on a pin write");

endmodule

bind interrupt_io_timer_interface iit_checker u_iit_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.read_data  (result.read_data),
	.intreq     (result.intreq),
	.int_level  (result.int_level),
	.pin_write  (result.pin_write),
	.pin_id     (result.pin_id),
	.pin_value  (result.pin_value)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for interrupt_io_timer_interface
// Drives bus reads, bit writes, line changes and decrementer ticks with random
// gaps and back-pressure. A status predictor computes the expected result word
// of each accepted input word, and every returned word is checked against it.
// ----------------------------------------------------------------------------
module testbench;

	import iit_pkg::*;

	// Predicts the status word of each accepted input word and keeps the
	// expectations in arrival order.
	class status_predictor;
		bit              timer_mode;
		bit [13:0]       clock_interval;
		bit              interval_changed;
		bit [13:0]       decrementer;
		bit [13:0]       latched_count;
		bit              timer_pending;
		bit [15:0]       int_enable;
		bit [15:0]       line_levels;
		bit [15:0]       pin_direction;
		bit [15:0]       pin_output;
		bit [15:0]       mirror_direction;
		bit [15:0]       mirror_output;
		bit [15:0]       pin_mask;
		result_t         expected_q[$];
		int unsigned     errors;

		// Lines that may raise an interrupt right now.
		function bit [15:0] active_lines();
			bit [15:0] cur;
			cur = line_levels;
			if (clock_interval != '0)
				cur[TimerLine] = timer_pending;
			return cur & int_enable & ~mirror_direction;
		endfunction

		// Dropping out of timer mode restarts the decrementer on a new interval.
		function void leave_timer();
			if (timer_mode) begin
				timer_mode = 1'b0;
				if (interval_changed)
					decrementer = clock_interval;
			end
		endfunction

		function bit [7:0] read_chunk(logic [1:0] chunk, logic [7:0] ext);
			bit [15:0] inv;
			bit [15:0] mirror_drive;
			bit [15:0] pin_drive;
			bit [7:0]  ans;
			inv = ~line_levels & pin_mask;
			mirror_drive = mirror_output & mirror_direction;
			pin_drive = pin_output & pin_direction;
			case (chunk_t'(chunk))
				CHUNK_LOW_LINES: begin
					if (timer_mode)
						ans = {latched_count[6:0], 1'b1};
					else
						ans = ((inv[7:0] | ext) & ~mirror_direction[7:0]) | mirror_drive[7:0];
				end
				CHUNK_HIGH_LINES: begin
					if (timer_mode)
						ans = {(active_lines() == '0), latched_count[13:7]};
					else
						ans = ((inv[15:8] | ext) & ~mirror_direction[15:8])
							| mirror_drive[15:8];
				end
				CHUNK_LOW_PINS: begin
					leave_timer();
					ans = (ext & ~pin_direction[7:0]) | pin_drive[7:0];
				end
				default: begin
					leave_timer();
					ans = (ext & ~pin_direction[15:8]) | pin_drive[15:8];
				end
			endcase
			return ans;
		endfunction

		// Applies one accepted input word and queues the status it yields.
		function void note_word(item_t w);
			result_t   r;
			bit [15:0] act;
			bit [3:0]  pin;
			bit [3:0]  mline;
			int        idx;
			int        n;
			r = '0;
			case (w.action)
				ACT_READ: r.read_data = read_chunk(w.bus_offset[1:0], w.external_byte);
				ACT_WRITE: begin
					if (w.bus_offset == OfsMode) begin
						if (timer_mode != w.bit_value) begin
							if (w.bit_value) begin
								timer_mode = 1'b1;
								latched_count = (clock_interval != '0) ? decrementer : '0;
								interval_changed = 1'b0;
							end else begin
								leave_timer();
							end
						end
					end else if (w.bus_offset <= OfsLastMask) begin
						if (timer_mode) begin
							idx = int'(w.bus_offset) - 1;
							clock_interval[idx] = w.bit_value;
							interval_changed = 1'b1;
						end else begin
							int_enable[w.bus_offset[3:0]] = w.bit_value;
							if (w.bus_offset[3:0] == TimerLine)
								timer_pending = 1'b0;
						end
					end else if (w.bus_offset == OfsSoftReset) begin
						if (timer_mode) begin
							if (!w.bit_value) begin
								pin_direction = '0;
								mirror_direction = '0;
								int_enable = '0;
							end
						end else begin
							int_enable[15] = w.bit_value;
						end
					end else begin
						pin = w.bus_offset[3:0];
						leave_timer();
						pin_direction[pin] = 1'b1;
						pin_output[pin] = w.bit_value;
						if (pin >= MirrorFirstPin) begin
							mline = 4'(MirrorBase - pin);
							mirror_direction[mline] = 1'b1;
							mirror_output[mline] = w.bit_value;
						end
						r.pin_write = 1'b1;
						r.pin_id = pin;
						r.pin_value = w.bit_value;
					end
				end
				ACT_LINE: line_levels[w.line_index] = w.bit_value;
				default: begin
					if (decrementer != '0) begin
						decrementer = decrementer - 1'b1;
						if (decrementer == '0) begin
							timer_pending = 1'b1;
							decrementer = clock_interval;
						end
					end
				end
			endcase
			act = active_lines();
			r.intreq = |act;
			for (n = 15; n >= 0; n--)
				if (act[n])
					r.int_level = 4'(n);
			expected_q.push_back(r);
		endfunction

		function string show(result_t r);
			return $sformatf("rd=%02h irq=%0b lvl=%0d pw=%0b pin=%0d val=%0b", r.read_data,
				r.intreq, r.int_level, r.pin_write, r.pin_id, r.pin_value);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		// Compares a returned status word with the oldest expectation.
		function void check_word(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				flag({"status word with nothing expected: ", show(got)});
				return;
			end
			want = expected_q.pop_front();
			if (got.read_data !== want.read_data || got.intreq !== want.intreq
				|| got.int_level !== want.int_level || got.pin_write !== want.pin_write
				|| got.pin_id !== want.pin_id || got.pin_value !== want.pin_value)
				flag({"status mismatch, expected ", show(want), ", got ", show(got)});
		endfunction
	endclass

	logic clk;
	logic arst_n;

	iit_item_if   item_ch ();
	iit_result_if status_ch ();
	iit_cfg_if    cfg_ch ();

	interrupt_io_timer_interface DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (status_ch),
		.cfg    (cfg_ch)
	);

	status_predictor model = new;
	int unsigned     words_sent;
	bit              idle_on;
	bit              hold_request;
	int              hold_left;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic item_t make_word(action_t a, logic [4:0] ofs, logic b,
		logic [3:0] ln, logic [7:0] xb);
		item_t w;
		w.action = a;
		w.bus_offset = ofs;
		w.bit_value = b;
		w.line_index = ln;
		w.external_byte = xb;
		return w;
	endfunction

	// Offers one word, with occasional idle cycles in front of it when idling is on.
	task automatic send_word(item_t w);
		if (idle_on) begin
			while ($urandom_range(99) < 8) begin
				item_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= w.action;
		item_ch.bus_offset <= w.bus_offset;
		item_ch.bit_value <= w.bit_value;
		item_ch.line_index <= w.line_index;
		item_ch.external_byte <= w.external_byte;
		do
			@(posedge clk);
		while (!item_ch.ready);
		words_sent++;
	endtask

	task automatic send_ticks(int count);
		repeat (count)
			send_word(make_word(ACT_TICK, 5'($urandom_range(31)), 1'($urandom_range(1)),
				4'($urandom_range(15)), 8'($urandom_range(255))));
	endtask

	// Waits until every expected status word has come back. The first edges
	// let the monitor record the last accepted word before the queue is read.
	task automatic drain();
		repeat (2) @(posedge clk);
		while (model.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Status receiver: random stalls, plus one long hold-off on request.
	initial begin
		status_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				status_ch.ready <= 1'b0;
			end else begin
				status_ch.ready <= !(idle_on && $urandom_range(99) < 8);
			end
		end
	end

	// Watches all three channels and feeds the predictor.
	always @(posedge clk) begin
		item_t   w;
		result_t r;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				model.pin_mask = cfg_ch.interrupt_pin_mask;
			if (status_ch.valid && status_ch.ready) begin
				r.read_data = status_ch.read_data;
				r.intreq = status_ch.intreq;
				r.int_level = status_ch.int_level;
				r.pin_write = status_ch.pin_write;
				r.pin_id = status_ch.pin_id;
				r.pin_value = status_ch.pin_value;
				model.check_word(r);
			end
			if (item_ch.valid && item_ch.ready) begin
				w = make_word(action_t'(item_ch.action), item_ch.bus_offset,
					item_ch.bit_value, item_ch.line_index, item_ch.external_byte);
				model.note_word(w);
			end
		end
	end

	// Stimulus: reset, then five phases, each with its own pin mask.
	initial begin
		int unsigned target;
		bit [15:0]   mask;
		bit [13:0]   span;
		int          kind;
		arst_n = 1'b0;
		idle_on = 1'b1;
		item_ch.valid = 1'b0;
		item_ch.action = ACT_READ;
		item_ch.bus_offset = '0;
		item_ch.bit_value = 1'b0;
		item_ch.line_index = '0;
		item_ch.external_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.interrupt_pin_mask = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: mask = 16'hFFFF;
				1: mask = 16'h0000;
				default: mask = 16'($urandom_range(16'hFFFF));
			endcase
			drain();
			cfg_ch.valid <= 1'b1;
			cfg_ch.interrupt_pin_mask <= mask;
			do
				@(posedge clk);
			while (!cfg_ch.ready);
			cfg_ch.valid <= 1'b0;
			// Phase 2 runs with no idling on either side.
			idle_on = (p != 2);
			if (p == 3)
				hold_request = 1'b1;

			if (p == 0) begin
				// Directed corners: mask bit 15, a timer run, pins and mirrors,
				// timer reads, soft reset and redundant mode writes.
				send_word(make_word(ACT_WRITE, OfsSoftReset, 1'b1, 4'd0, 8'h00));
				send_word(make_word(ACT_LINE, 5'd0, 1'b1, 4'd15, 8'h00));
				send_word(make_word(ACT_WRITE, 5'd3, 1'b1, 4'd0, 8'h00));
				send_word(make_word(ACT_WRITE, OfsMode, 1'b1, 4'd0, 8'h00));
				send_word(make_word(ACT_WRITE, 5'd1, 1'b1, 4'd0, 8'h00));
				send_word(make_word(ACT_WRITE, OfsLastMask, 1'b1, 4'd0, 8'h00));
				send_word(make_word(ACT_READ, 5'd0, 1'b0, 4'd0, 8'hFF));
				send_word(make_word(ACT_READ, 5'd1, 1'b0, 4'd0, 8'hFF));
				send_word(make_word(ACT_WRITE, OfsLastMask, 1'b0, 4'd0, 8'h00));
				send_word(make_word(ACT_READ, 5'd2, 1'b0, 4'd0, 8'hFF));
				send_word(make_word(ACT_TICK, 5'd0, 1'b0, 4'd0, 8'h00));
				send_word(make_word(ACT_WRITE, 5'd3, 1'b0, 4'd0, 8'h00));
				send_word(make_word(ACT_WRITE, OfsFirstPin, 1'b1, 4'd0, 8'h00));
				send_word(make_word(ACT_WRITE, 5'd31, 1'b1, 4'd0, 8'h00));
				send_word(make_word(ACT_WRITE, 5'd23, 1'b0, 4'd0, 8'h00));
				send_word(make_word(ACT_READ, 5'd0, 1'b0, 4'd0, 8'h00));
				send_word(make_word(ACT_READ, 5'd1, 1'b1, 4'd15, 8'hFF));
				send_word(make_word(ACT_READ, 5'd3, 1'b0, 4'd0, 8'h00));
				send_word(make_word(ACT_READ, 5'd31, 1'b0, 4'd0, 8'hA5));
				send_word(make_word(ACT_WRITE, OfsMode, 1'b1, 4'd0, 8'h00));
				send_word(make_word(ACT_WRITE, OfsSoftReset, 1'b1, 4'd0, 8'h00));
				send_word(make_word(ACT_WRITE, OfsSoftReset, 1'b0, 4'd0, 8'h00));
				send_word(make_word(ACT_WRITE, OfsMode, 1'b0, 4'd0, 8'h00));
				send_word(make_word(ACT_WRITE, OfsMode, 1'b0, 4'd0, 8'h00));
				send_word(make_word(ACT_LINE, 5'd0, 1'b1, 4'd0, 8'h00));
				send_word(make_word(ACT_LINE, 5'd0, 1'b0, 4'd15, 8'h00));
			end

			// Random part: mostly well-formed sequences, some noise.
			target = words_sent + 400;
			while (words_sent < target) begin
				kind = $urandom_range(99);
				if (kind < 25) begin
					// Program an interval, leave timer mode and let it count.
					send_word(make_word(ACT_WRITE, OfsMode, 1'b1, 4'($urandom_range(15)),
						8'($urandom_range(255))));
					if ($urandom_range(3) == 0)
						span = 14'($urandom_range(14'h3FFF));
					else
						span = 14'($urandom_range(12));
					for (int i = 1; i <= 14; i++)
						send_word(make_word(ACT_WRITE, 5'(i), span[i-1], 4'($urandom_range(15)),
							8'($urandom_range(255))));
					repeat ($urandom_range(2))
						send_word(make_word(ACT_READ, {3'($urandom_range(7)), 1'b0,
							1'($urandom_range(1))}, 1'($urandom_range(1)),
							4'($urandom_range(15)), 8'($urandom_range(255))));
					case ($urandom_range(2))
						0: send_word(make_word(ACT_WRITE, OfsMode, 1'b0, 4'($urandom_range(15)),
							8'($urandom_range(255))));
						1: send_word(make_word(ACT_READ, {3'($urandom_range(7)), 1'b1,
							1'($urandom_range(1))}, 1'($urandom_range(1)),
							4'($urandom_range(15)), 8'($urandom_range(255))));
						default: send_word(make_word(ACT_WRITE, 5'($urandom_range(31, 16)),
							1'($urandom_range(1)), 4'($urandom_range(15)),
							8'($urandom_range(255))));
					endcase
					send_ticks($urandom_range(30, 1));
				end else if (kind < 37) begin
					// Mask and soft reset writes in whatever mode the block is in.
					repeat ($urandom_range(4, 1))
						send_word(make_word(ACT_WRITE, 5'($urandom_range(15, 1)),
							1'($urandom_range(1)), 4'($urandom_range(15)),
							8'($urandom_range(255))));
				end else if (kind < 52) begin
					repeat ($urandom_range(4, 1))
						send_word(make_word(ACT_LINE, 5'($urandom_range(31)),
							1'($urandom_range(1)), 4'($urandom_range(15)),
							8'($urandom_range(255))));
				end else if (kind < 62) begin
					repeat ($urandom_range(3, 1))
						send_word(make_word(ACT_WRITE, 5'($urandom_range(31, 16)),
							1'($urandom_range(1)), 4'($urandom_range(15)),
							8'($urandom_range(255))));
				end else if (kind < 80) begin
					repeat ($urandom_range(3, 1))
						send_word(make_word(ACT_READ, 5'($urandom_range(31)),
							1'($urandom_range(1)), 4'($urandom_range(15)),
							8'($urandom_range(255))));
				end else if (kind < 88) begin
					send_ticks($urandom_range(10, 1));
				end else if (kind < 95) begin
					// Soft reset attempt inside a timer mode window.
					send_word(make_word(ACT_WRITE, OfsMode, 1'b1, 4'($urandom_range(15)),
						8'($urandom_range(255))));
					send_word(make_word(ACT_WRITE, OfsSoftReset, 1'($urandom_range(1)),
						4'($urandom_range(15)), 8'($urandom_range(255))));
					send_word(make_word(ACT_WRITE, OfsMode, 1'b0, 4'($urandom_range(15)),
						8'($urandom_range(255))));
				end else begin
					repeat ($urandom_range(3, 1))
						send_word(make_word(action_t'($urandom_range(3)), 5'($urandom_range(31)),
							1'($urandom_range(1)), 4'($urandom_range(15)),
							8'($urandom_range(255))));
				end
			end
			item_ch.valid <= 1'b0;
		end

		drain();
		repeat (10) @(posedge clk);
		model.errors += model.expected_q.size();
		if (model.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/iit_pkg.sv
hw/rtl/iit_ifs.sv
hw/rtl/iit_core.sv
hw/rtl/interrupt_io_timer_interface.sv
hw/rtl/iit_checker.sv
tb/testbench.sv
